@@ rtl/spf_pkg.sv @@
// ----------------------------------------------------------------------------
// spf_pkg - shared types and constants for the setpoint frame receiver
// Frame header codes, length limit, payload window layout and the fixed
// reciprocal used to divide speed words by ten.
// ----------------------------------------------------------------------------
package spf_pkg;

  // frame layout
  localparam logic [7:0] HEAD_FIRST    = 8'hAA;
  localparam logic [7:0] HEAD_SECOND   = 8'hAF;
  localparam logic [7:0] FUNC_MAX      = 8'hF0;
  localparam logic [7:0] FUNC_SETPOINT = 8'h01;
  localparam logic [7:0] LENGTH_LIMIT  = 8'd50;

  // payload offsets that the decode reads
  localparam int WINDOW_DEPTH = 18;
  localparam int WINDOW_IDX_W = $clog2(WINDOW_DEPTH);
  localparam int COUNT_W      = 6;
  localparam int MOTORS       = 4;
  localparam int GAINS        = 3;

  // result field widths
  localparam int SPEED_W = 13;
  localparam int QUOT_W  = SPEED_W - 1;
  localparam int GAIN_W  = 16;

  // x / 10 == (x * 52429) >> 19 for every 16-bit magnitude
  localparam int RECIP_W              = 17;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 17'd52429;
  localparam int RECIP_SHIFT          = 19;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEAD1,
    PH_HEAD2,
    PH_FUNC,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  typedef logic [WINDOW_DEPTH-1:0][7:0] window_t;

endpackage

@@ rtl/setpoint_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// setpoint_frame_receiver - serial setpoint frame parser and decoder
// Parses 0xAA 0xAF framed packets with a byte-sum checksum and decodes
// motor directions, speeds and gains from good setpoint frames.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : one received byte per beat on rx_byte, in_valid/in_stall
//   output channel : one setpoint beat per good function-1 frame,
//                    out_valid/out_stall, eleven field ports
// Throughput: one byte per cycle while in_stall is low. The parser handles each byte
//   in the cycle it is taken, so there is no per-byte loop.
// Path: after the checksum byte is taken the result beat passes the decode request,
//   field extract and divide-by-ten result registers in that order.
// Reset (rst, synchronous): parser back to idle, sum and counters zero,
//   payload window all zero, the decode pipeline empty.
// Stall: a stalled result waits in the output register while bytes keep
//   flowing; in_stall rises only when the output register and the extract
//   stage both hold frames that cannot move and a third decoded frame is
//   pending behind them, since the window it reads must hold still.
// ----------------------------------------------------------------------------
module setpoint_frame_receiver
  import spf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                dir_one,
  output logic [7:0]                dir_two,
  output logic [7:0]                dir_three,
  output logic [7:0]                dir_four,
  output logic signed [SPEED_W-1:0] speed_one,
  output logic signed [SPEED_W-1:0] speed_two,
  output logic signed [SPEED_W-1:0] speed_three,
  output logic signed [SPEED_W-1:0] speed_four,
  output logic signed [GAIN_W-1:0]  gain_prop,
  output logic signed [GAIN_W-1:0]  gain_integ,
  output logic signed [GAIN_W-1:0]  gain_deriv
);

  window_t                   window;
  logic                      dec_valid;
  logic                      dec_take;
  logic [MOTORS-1:0][7:0]    dirs;
  logic signed [SPEED_W-1:0] speeds [MOTORS];
  logic signed [GAIN_W-1:0]  gains [GAINS];

  // byte parser and payload window
  spf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .window    (window),
    .dec_valid (dec_valid),
    .dec_take  (dec_take)
  );

  // field decode and result register
  spf_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .dec_valid (dec_valid),
    .window    (window),
    .dec_take  (dec_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dirs      (dirs),
    .speeds    (speeds),
    .gains     (gains)
  );

  // result fields
  assign dir_one     = dirs[0];
  assign dir_two     = dirs[1];
  assign dir_three   = dirs[2];
  assign dir_four    = dirs[3];
  assign speed_one   = speeds[0];
  assign speed_two   = speeds[1];
  assign speed_three = speeds[2];
  assign speed_four  = speeds[3];
  assign gain_prop   = gains[0];
  assign gain_integ  = gains[1];
  assign gain_deriv  = gains[2];

  // input held back only behind a queued decode
  a_stall_needs_pending: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (dec_valid && !dec_take))
    else $error("input stalled with no blocked decode");

  // with an empty result register the whole chain drains
  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the result register is empty");

  // the window a pending decode reads does not move
  a_window_held: assert property (@(posedge clk) disable iff (rst)
    (dec_valid && !dec_take) |=> $stable(window))
    else $error("payload window changed under a pending decode");

endmodule

@@ rtl/spf_parser.sv @@
// ----------------------------------------------------------------------------
// spf_parser - byte-level frame parser
// Walks the header, length, payload and checksum of each frame, keeps the
// payload window and raises a decode request for a good setpoint frame.
// ----------------------------------------------------------------------------
module spf_parser
  import spf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output window_t    window,
  output logic       dec_valid,
  input  logic       dec_take
);

  phase_t               phase, phase_next;
  logic [7:0]           func_code, func_code_next;
  logic [COUNT_W-1:0]   bytes_left, bytes_left_next;
  logic [COUNT_W-1:0]   bytes_taken, bytes_taken_next;
  logic [7:0]           running_sum, running_sum_next;
  logic                 store_req;
  logic                 fire;
  logic                 accept;
  logic                 store_en;
  logic [WINDOW_IDX_W-1:0] store_idx;

  // a pending decode that cannot move holds the window, so hold the input
  assign in_stall = dec_valid && !dec_take;
  assign accept   = in_valid && !in_stall;

  // next phase
  always_comb begin
    phase_next = PH_IDLE;
    case (phase)
      PH_IDLE:    if (rx_byte == HEAD_FIRST) phase_next = PH_HEAD1;
      PH_HEAD1:   if (rx_byte == HEAD_SECOND) phase_next = PH_HEAD2;
      PH_HEAD2:   if (rx_byte != 8'd0 && rx_byte <= FUNC_MAX) phase_next = PH_FUNC;
      PH_FUNC:    if (rx_byte < LENGTH_LIMIT) phase_next = PH_PAYLOAD;
      PH_PAYLOAD: begin
        if (bytes_left != '0) begin
          phase_next = (bytes_left == COUNT_W'(1)) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_CHECK:   phase_next = PH_IDLE;
      default:    phase_next = PH_IDLE;
    endcase
  end

  // datapath updates for the byte in the current phase
  always_comb begin
    func_code_next   = func_code;
    bytes_left_next  = bytes_left;
    bytes_taken_next = bytes_taken;
    running_sum_next = running_sum;
    store_req        = 1'b0;
    fire             = 1'b0;
    case (phase)
      PH_IDLE:  running_sum_next = rx_byte;
      PH_HEAD1: running_sum_next = running_sum + rx_byte;
      PH_HEAD2: begin
        func_code_next   = rx_byte;
        running_sum_next = running_sum + rx_byte;
      end
      PH_FUNC: begin
        bytes_left_next  = rx_byte[COUNT_W-1:0];
        bytes_taken_next = '0;
        running_sum_next = running_sum + rx_byte;
      end
      PH_PAYLOAD: begin
        if (bytes_left != '0) begin
          bytes_left_next  = bytes_left - COUNT_W'(1);
          bytes_taken_next = bytes_taken + COUNT_W'(1);
          running_sum_next = running_sum + rx_byte;
          store_req        = 1'b1;
        end
      end
      PH_CHECK: begin
        store_req = 1'b1;
        fire      = (running_sum == rx_byte) && (func_code == FUNC_SETPOINT);
      end
      default: ;
    endcase
  end

  // only offsets inside the window are kept
  assign store_idx = bytes_taken[WINDOW_IDX_W-1:0];
  assign store_en  = accept && store_req && (bytes_taken < COUNT_W'(WINDOW_DEPTH));

  // parser state; sum and counters only move on a phase that accepts the byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      func_code   <= '0;
      bytes_left  <= '0;
      bytes_taken <= '0;
      running_sum <= '0;
    end else if (accept) begin
      phase <= phase_next;
      if (phase_next != PH_IDLE || phase == PH_CHECK) begin
        func_code   <= func_code_next;
        bytes_left  <= bytes_left_next;
        bytes_taken <= bytes_taken_next;
        running_sum <= running_sum_next;
      end
    end
  end

  // payload window, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (store_en) begin
      window[store_idx] <= rx_byte;
    end
  end

  // decode request for a good setpoint frame
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (accept && fire) begin
      dec_valid <= 1'b1;
    end else if (dec_take) begin
      dec_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/spf_decode.sv @@
// ----------------------------------------------------------------------------
// spf_decode - setpoint decode pipeline
// Pulls directions, speed magnitudes and gains out of the payload window,
// then divides the speeds by ten into the result register.
// ----------------------------------------------------------------------------
module spf_decode
  import spf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     dec_valid,
  input  window_t                  window,
  output logic                     dec_take,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [MOTORS-1:0][7:0]   dirs,
  output logic signed [SPEED_W-1:0] speeds [MOTORS],
  output logic signed [GAIN_W-1:0]  gains [GAINS]
);

  logic                  s2_valid;
  logic                  s2_ok;
  logic                  out_ok;
  logic                  out_load;
  logic [MOTORS-1:0][7:0] s2_dir;
  logic [15:0]           s2_mag [MOTORS];
  logic [MOTORS-1:0]     s2_neg;
  logic [GAIN_W-1:0]     s2_gain [GAINS];
  logic [15:0]           word_mag [MOTORS];
  logic [MOTORS-1:0]     word_neg;
  logic [15+RECIP_W:0]   prod [MOTORS];
  logic [QUOT_W-1:0]     quot [MOTORS];

  // handshake along the two stages
  assign out_ok   = !out_valid || !out_stall;
  assign out_load = s2_valid && out_ok;
  assign s2_ok    = !s2_valid || out_ok;
  assign dec_take = dec_valid && s2_ok;

  // sign and magnitude of each big-endian speed word
  for (genvar m = 0; m < MOTORS; m++) begin : g_mag
    localparam int Hi = 3 * m + 1;
    logic [15:0] word;
    assign word        = {window[Hi], window[Hi + 1]};
    assign word_neg[m] = word[15];
    assign word_mag[m] = word[15] ? (~word + 16'd1) : word;
  end

  // first stage: fields out of the window
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ok) begin
      s2_valid <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_take) begin
      for (int m = 0; m < MOTORS; m++) begin
        s2_dir[m] <= window[3 * m];
        s2_mag[m] <= word_mag[m];
      end
      s2_neg <= word_neg;
      for (int g = 0; g < GAINS; g++) begin
        s2_gain[g] <= {window[2 * MOTORS * 1 + 4 + 2 * g], window[2 * MOTORS * 1 + 5 + 2 * g]};
      end
    end
  end

  // divide by ten through the reciprocal, truncating toward zero
  for (genvar m = 0; m < MOTORS; m++) begin : g_div
    assign prod[m] = s2_mag[m] * RECIP_TEN;
    assign quot[m] = prod[m][RECIP_SHIFT +: QUOT_W];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ok) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dirs <= s2_dir;
      for (int m = 0; m < MOTORS; m++) begin
        speeds[m] <= s2_neg[m] ? -$signed({1'b0, quot[m]}) : $signed({1'b0, quot[m]});
      end
      for (int g = 0; g < GAINS; g++) begin
        gains[g] <= $signed(s2_gain[g]);
      end
    end
  end

endmodule

@@ verif/setpoint_frame_receiver_test.sv @@
// ----------------------------------------------------------------------------
// setpoint_frame_receiver_test - self-checking bench for the frame receiver
// Feeds a short scripted byte sequence and then randomized frames, broken
// headers and line noise through the byte channel with random gaps. A
// byte-level model of the parser predicts each decoded setpoint beat, and
// every beat taken from the output channel is checked field by field.
// ----------------------------------------------------------------------------
module setpoint_frame_receiver_test;
  import spf_pkg::*;

  localparam int ITEM_TARGET   = 1650;
  localparam int DRAIN_EVERY   = 500;
  localparam int GAP_MAX       = 18;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;

  // one decoded setpoint, index 0 is motor one / the proportional gain
  typedef struct packed {
    logic [MOTORS-1:0][7:0]         dir;
    logic [MOTORS-1:0][SPEED_W-1:0] speed;
    logic [GAINS-1:0][GAIN_W-1:0]   gain;
  } setpoint_t;

  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    setpoint_t  want;
  } script_row_t;

  localparam setpoint_t NO_WANT = '0;
  // window after the first frame: 0x7F at offset 0, checksum 0xDA at offset 1,
  // so speed one is 0xDA00 / 10 = -972 (0x1C34 in 13 bits)
  localparam setpoint_t FIRST_WANT = '{dir: 32'h0000_007F, speed: 52'h1C34, gain: '0};

  localparam int SCRIPT_LEN = 24;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // good setpoint frame straight after reset, length one
    '{HEAD_FIRST,        1'b0, NO_WANT},
    '{HEAD_SECOND,       1'b0, NO_WANT},
    '{FUNC_SETPOINT,     1'b0, NO_WANT},
    '{8'h01,             1'b0, NO_WANT},
    '{8'h7F,             1'b0, NO_WANT},
    '{8'hDA,             1'b1, FIRST_WANT},
    // wrong second byte: the repeated head byte is eaten, not a restart
    '{HEAD_FIRST,        1'b0, NO_WANT},
    '{HEAD_FIRST,        1'b0, NO_WANT},
    '{HEAD_SECOND,       1'b0, NO_WANT},
    // function zero is refused
    '{HEAD_FIRST,        1'b0, NO_WANT},
    '{HEAD_SECOND,       1'b0, NO_WANT},
    '{8'h00,             1'b0, NO_WANT},
    // function one past the top is refused
    '{HEAD_FIRST,        1'b0, NO_WANT},
    '{HEAD_SECOND,       1'b0, NO_WANT},
    '{FUNC_MAX + 8'd1,   1'b0, NO_WANT},
    // zero length: whatever comes next drops back to idle
    '{HEAD_FIRST,        1'b0, NO_WANT},
    '{HEAD_SECOND,       1'b0, NO_WANT},
    '{FUNC_SETPOINT,     1'b0, NO_WANT},
    '{8'h00,             1'b0, NO_WANT},
    '{HEAD_FIRST,        1'b0, NO_WANT},
    // length at the limit is refused
    '{HEAD_FIRST,        1'b0, NO_WANT},
    '{HEAD_SECOND,       1'b0, NO_WANT},
    '{FUNC_SETPOINT,     1'b0, NO_WANT},
    '{LENGTH_LIMIT,      1'b0, NO_WANT}
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                rx_byte = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [7:0]                dir_one, dir_two, dir_three, dir_four;
  logic signed [SPEED_W-1:0] speed_one, speed_two, speed_three, speed_four;
  logic signed [GAIN_W-1:0]  gain_prop, gain_integ, gain_deriv;

  setpoint_frame_receiver dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dir_one     (dir_one),
    .dir_two     (dir_two),
    .dir_three   (dir_three),
    .dir_four    (dir_four),
    .speed_one   (speed_one),
    .speed_two   (speed_two),
    .speed_three (speed_three),
    .speed_four  (speed_four),
    .gain_prop   (gain_prop),
    .gain_integ  (gain_integ),
    .gain_deriv  (gain_deriv)
  );

  always #5 clk = ~clk;

  // parser shadow state
  phase_t             frame_phase;
  logic [7:0]         frame_func;
  logic [COUNT_W-1:0] payload_left;
  logic [COUNT_W-1:0] payload_count;
  logic [7:0]         byte_sum;
  logic [7:0]         shadow_window [WINDOW_DEPTH];

  setpoint_t   pending_setpoints [$];
  int unsigned frame_bytes = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int          stall_left = 0;
  bit          send_calm = 1'b0;
  bit          take_calm = 1'b0;

  // decode directions, speeds over ten and raw gains from the shadow window
  function automatic setpoint_t decode_window();
    setpoint_t          sp;
    logic signed [15:0] raw_word;
    int                 quot;
    for (int m = 0; m < MOTORS; m++) begin
      sp.dir[m] = shadow_window[3*m];
      raw_word = {shadow_window[3*m+1], shadow_window[3*m+2]};
      quot = raw_word / 10;
      sp.speed[m] = quot[SPEED_W-1:0];
    end
    for (int g = 0; g < GAINS; g++) begin
      sp.gain[g] = {shadow_window[12+2*g], shadow_window[13+2*g]};
    end
    return sp;
  endfunction

  // advance the shadow parser by one byte, report a decoded setpoint
  task automatic track_byte(input logic [7:0] b, output logic fired, output setpoint_t sp);
    fired = 1'b0;
    sp = '0;
    if (frame_phase == PH_IDLE && b == HEAD_FIRST) begin
      frame_phase = PH_HEAD1;
      byte_sum = b;
    end else if (frame_phase == PH_HEAD1 && b == HEAD_SECOND) begin
      frame_phase = PH_HEAD2;
      byte_sum += b;
    end else if (frame_phase == PH_HEAD2 && b != 8'h00 && b <= FUNC_MAX) begin
      frame_phase = PH_FUNC;
      frame_func = b;
      byte_sum += b;
    end else if (frame_phase == PH_FUNC && b < LENGTH_LIMIT) begin
      frame_phase = PH_PAYLOAD;
      payload_left = b[COUNT_W-1:0];
      payload_count = '0;
      byte_sum += b;
    end else if (frame_phase == PH_PAYLOAD && payload_left != '0) begin
      payload_left -= 1'b1;
      if (payload_count < WINDOW_DEPTH) shadow_window[payload_count] = b;
      payload_count += 1'b1;
      byte_sum += b;
      if (payload_left == '0) frame_phase = PH_CHECK;
    end else if (frame_phase == PH_CHECK) begin
      // the checksum byte lands in the window too
      frame_phase = PH_IDLE;
      if (payload_count < WINDOW_DEPTH) shadow_window[payload_count] = b;
      if (byte_sum == b && frame_func == FUNC_SETPOINT) begin
        fired = 1'b1;
        sp = decode_window();
      end
    end else begin
      frame_phase = PH_IDLE;
    end
  endtask

  // present one byte after a random gap, wait for the beat, then predict
  task automatic send_byte(input logic [7:0] b, input logic typed, input setpoint_t want);
    int        gap;
    logic      fired;
    logic      was_idle;
    setpoint_t sp;
    gap = send_calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    was_idle = (frame_phase == PH_IDLE);
    track_byte(b, fired, sp);
    if (!(was_idle && frame_phase == PH_IDLE)) frame_bytes++;
    if (fired) begin
      pending_setpoints.push_back(typed ? want : sp);
    end
  endtask

  // hold the byte channel until every predicted beat has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_setpoints.size() != 0);
  endtask

  task automatic flag_mismatch(input string what, input int want_v, input int seen_v);
    if (mismatch_count < REPORT_LIMIT) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want_v, seen_v);
    end
    mismatch_count++;
  endtask

  // result side: check each beat, then stall for a random number of cycles
  always @(posedge clk) begin
    setpoint_t seen;
    setpoint_t want;
    int        gap;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      seen.dir = {dir_four, dir_three, dir_two, dir_one};
      seen.speed = {speed_four, speed_three, speed_two, speed_one};
      seen.gain = {gain_deriv, gain_integ, gain_prop};
      if (pending_setpoints.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT) begin
          $display("setpoint beat with none expected: dir_one %0d speed_one %0d",
                   dir_one, speed_one);
        end
        mismatch_count++;
      end else begin
        want = pending_setpoints.pop_front();
        for (int m = 0; m < MOTORS; m++) begin
          if (seen.dir[m] !== want.dir[m]) begin
            flag_mismatch($sformatf("dir[%0d]", m), int'(want.dir[m]), int'(seen.dir[m]));
          end
          if (seen.speed[m] !== want.speed[m]) begin
            flag_mismatch($sformatf("speed[%0d]", m), int'($signed(want.speed[m])),
                          int'($signed(seen.speed[m])));
          end
        end
        for (int g = 0; g < GAINS; g++) begin
          if (seen.gain[g] !== want.gain[g]) begin
            flag_mismatch($sformatf("gain[%0d]", g), int'($signed(want.gain[g])),
                          int'($signed(seen.gain[g])));
          end
        end
      end
      results_seen++;
      if (results_seen % 8 == 0) take_calm = ($urandom_range(0, 2) == 0);
      gap = take_calm ? 0 : $urandom_range(0, GAP_MAX);
      stall_left <= gap;
      out_stall <= (gap != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  // stimulus
  initial begin
    logic [7:0]  frame [$];
    logic [7:0]  fn;
    logic [7:0]  chk;
    int          kind;
    int          r;
    int          len;
    int          cut;
    int unsigned next_drain;
    frame_phase = PH_IDLE;
    frame_func = '0;
    payload_left = '0;
    payload_count = '0;
    byte_sum = '0;
    foreach (shadow_window[i]) shadow_window[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // scripted sequence
    foreach (SCRIPT[i]) send_byte(SCRIPT[i].data, SCRIPT[i].typed, SCRIPT[i].want);
    drain_results();

    // random frames, broken headers and line noise
    next_drain = frame_bytes + DRAIN_EVERY;
    while (frame_bytes < ITEM_TARGET) begin
      if (frame_bytes >= next_drain) begin
        drain_results();
        next_drain += DRAIN_EVERY;
      end
      send_calm = ($urandom_range(0, 3) == 0);
      frame.delete();
      kind = $urandom_range(0, 99);
      if (kind < 78) begin
        // well-formed frame, mostly setpoints with short payloads
        r = $urandom_range(0, 9);
        fn = (r < 7) ? FUNC_SETPOINT : (r == 7) ? FUNC_MAX : 8'($urandom_range(2, FUNC_MAX));
        r = $urandom_range(0, 19);
        len = (r < 15) ? $urandom_range(0, WINDOW_DEPTH)
            : (r < 19) ? $urandom_range(WINDOW_DEPTH + 1, LENGTH_LIMIT - 1)
            : LENGTH_LIMIT - 1;
        frame = '{HEAD_FIRST, HEAD_SECOND, fn, 8'(len)};
        for (int j = 0; j < len; j++) begin
          r = $urandom_range(0, 11);
          frame.push_back(r == 0 ? 8'h7F : r == 1 ? 8'h80 : r == 2 ? 8'hFF :
                          r == 3 ? 8'h00 : 8'($urandom));
        end
        chk = '0;
        foreach (frame[j]) chk += frame[j];
        if ($urandom_range(0, 7) == 0) chk ^= 8'($urandom_range(1, 255));
        frame.push_back(chk);
        // now and then the frame is cut short
        if ($urandom_range(0, 11) == 0) begin
          cut = $urandom_range(0, frame.size() - 2);
          frame = frame[0:cut];
        end
      end else if (kind < 90) begin
        // header or field out of range
        case ($urandom_range(0, 2))
          0: frame = '{HEAD_FIRST, 8'($urandom)};
          1: frame = '{HEAD_FIRST, HEAD_SECOND,
                       ($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(FUNC_MAX + 1, 255)))};
          default: frame = '{HEAD_FIRST, HEAD_SECOND, FUNC_SETPOINT,
                             8'($urandom_range(LENGTH_LIMIT, 255))};
        endcase
      end else begin
        repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
      end
      foreach (frame[j]) send_byte(frame[j], 1'b0, NO_WANT);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("setpoint_frame_receiver verification clean");
    end else begin
      $display("setpoint_frame_receiver verification failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("setpoint_frame_receiver verification failed");
    $finish;
  end

endmodule
